// File: rtl/core/image_intensity_centroid_assert.svh
// Assertion macros shared by the centroid modules.
// Each module that uses them has a clock named clk and a reset named rst.
`ifndef IMAGE_INTENSITY_CENTROID_ASSERT_SVH
`define IMAGE_INTENSITY_CENTROID_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ICC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ICC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/icc_pkg.sv
package icc_pkg;

  // Fixed field widths of the ports.
  localparam int PIXEL_W    = 16;
  localparam int SIZE_W     = 11;
  localparam int PED_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_OUT_W  = 37;
  localparam int CENT_W     = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_PEDESTAL     = 2'd2
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [PED_W-1:0]  PED_RST    = 16'd32;

  // Saturation limits of a centroid.
  localparam logic [CENT_W-1:0] CENT_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [CENT_W-1:0] CENT_NEG_SAT = 32'h8000_0000;

  // Configuration registers as seen by the accumulator.
  typedef struct packed {
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
    logic [PED_W-1:0]  pedestal;
  } cfg_regs_t;

endpackage

// File: rtl/core/icc_fifo.sv
module icc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW  = $clog2(DEPTH),
  localparam int CNW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CNW-1:0]   count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  assign rdata = mem[rd_ptr];
  assign empty = (count == '0);

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/icc_front.sv
module icc_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int SUM_W      = 37,
  parameter int MOM_W      = 47,
  parameter int Q_DEPTH    = 2,
  localparam int QCW = $clog2(Q_DEPTH + 1),
  localparam int QW  = SUM_W + 2 * MOM_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  icc_pkg::cfg_regs_t           cfg,
  input  logic [icc_pkg::PIXEL_W-1:0]  pixel,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [QCW-1:0]               q_count,
  output logic                         q_push,
  output logic [QW-1:0]                q_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int V_W  = icc_pkg::PIXEL_W + 1;
  localparam int XP_W = V_W + CW + 1;
  localparam int YP_W = V_W + RW + 1;

  logic [CW-1:0] col_count;
  logic [CW-1:0] last_col;
  logic [RW-1:0] row_count;
  logic [RW-1:0] last_row;
  logic          row_end;
  logic          at_last;
  logic          accept;
  logic [QCW:0]  slots_used;

  logic                 a_valid;
  logic                 a_last;
  logic signed [V_W-1:0] a_v;
  logic [CW-1:0]        a_col;
  logic [RW-1:0]        a_row;

  logic                  b_valid;
  logic                  b_last;
  logic signed [V_W-1:0] b_v;
  logic signed [XP_W-1:0] b_xp;
  logic signed [YP_W-1:0] b_yp;

  logic signed [SUM_W-1:0] sum_acc;
  logic signed [MOM_W-1:0] x_moment;
  logic signed [MOM_W-1:0] y_moment;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [MOM_W-1:0] x_moment_next;
  logic signed [MOM_W-1:0] y_moment_next;

  // Last column and row index from the size registers, clamped to the frame limits.
  always_comb begin
    if (cfg.image_width == '0) begin
      last_col = '0;
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(cfg.image_width - 1'b1);
    end
    if (cfg.image_height == '0) begin
      last_row = '0;
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(cfg.image_height - 1'b1);
    end
  end

  assign row_end = (col_count >= last_col);
  assign at_last = row_end && (row_count >= last_row);

  // A frame's last pixel needs a queue slot for its totals, counting frames still in flight.
  assign slots_used = (QCW + 1)'(q_count) + (QCW + 1)'(a_valid && a_last)
                    + (QCW + 1)'(b_valid && b_last);
  assign in_stall   = at_last && (slots_used >= (QCW + 1)'(Q_DEPTH));
  assign accept     = in_valid && !in_stall;

  // Raster position of the next pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= at_last ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // Stage A: pedestal subtraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_v    <= {1'b0, pixel} - {1'b0, cfg.pedestal};
    a_col  <= col_count;
    a_row  <= row_count;
    a_last <= at_last;
  end

  // Stage B: column and row weighting.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_v    <= a_v;
    b_xp   <= a_v * $signed({1'b0, a_col});
    b_yp   <= a_v * $signed({1'b0, a_row});
    b_last <= a_last;
  end

  // Accumulation; the frame totals go to the queue and the sums restart.
  assign sum_next      = sum_acc + SUM_W'(b_v);
  assign x_moment_next = x_moment + MOM_W'(b_xp);
  assign y_moment_next = y_moment + MOM_W'(b_yp);

  assign q_push = b_valid && b_last;
  assign q_data = {sum_next, x_moment_next, y_moment_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc  <= '0;
      x_moment <= '0;
      y_moment <= '0;
    end else if (b_valid) begin
      if (b_last) begin
        sum_acc  <= '0;
        x_moment <= '0;
        y_moment <= '0;
      end else begin
        sum_acc  <= sum_next;
        x_moment <= x_moment_next;
        y_moment <= y_moment_next;
      end
    end
  end

`include "image_intensity_centroid_assert.svh"

  `ICC_ASSERT_IMP(a_push_has_room, q_push, q_count < QCW'(Q_DEPTH), "queue overflow at frame end")
  `ICC_ASSERT_NXT(a_frame_end_counts, accept && at_last, col_count == '0 && row_count == '0, "raster position not restarted")
  `ICC_ASSERT_NXT(a_push_clears_sums, q_push, sum_acc == '0 && x_moment == '0 && y_moment == '0, "sums not cleared after frame")

endmodule

// File: rtl/core/icc_back.sv
module icc_back #(
  parameter int SUM_W     = 37,
  parameter int MOM_W     = 47,
  parameter int FRAC_BITS = 8,
  localparam int QW = SUM_W + 2 * MOM_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [QW-1:0]                 q_data,
  output logic                          q_pop,
  output logic [icc_pkg::SUM_OUT_W-1:0] pixel_sum,
  output logic [icc_pkg::CENT_W-1:0]    centroid_x,
  output logic [icc_pkg::CENT_W-1:0]    centroid_y,
  output logic                          zero_sum,
  output logic                          out_valid,
  input  logic                          out_stall
);

  localparam int NB  = MOM_W + FRAC_BITS;
  localparam int SCW = $clog2(NB + 1);
  localparam int CW  = icc_pkg::CENT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t state;
  logic [SCW-1:0] step;

  logic signed [SUM_W-1:0] q_sum;
  logic signed [MOM_W-1:0] q_mom [2];
  logic [SUM_W-1:0]        q_den;
  logic                    q_zero;

  // Per-lane divider state: lane 0 is x, lane 1 is y.
  logic signed [SUM_W-1:0] sum_reg;
  logic                    zero_reg;
  logic [SUM_W-1:0]        den;
  logic [NB-1:0]           dvd [2];
  logic [SUM_W-1:0]        rem [2];
  logic [CW-1:0]           quo [2];
  logic                    sat [2];
  logic                    neg [2];

  logic [SUM_W:0]          trial    [2];
  logic                    fits     [2];
  logic [SUM_W-1:0]        rem_next [2];
  logic [MOM_W-1:0]        mom_abs  [2];
  logic [CW-1:0]           cent     [2];

  // Frame totals at the head of the queue.
  assign q_sum    = q_data[QW-1 -: SUM_W];
  assign q_mom[0] = q_data[2*MOM_W-1 -: MOM_W];
  assign q_mom[1] = q_data[MOM_W-1:0];
  assign q_den    = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : q_sum;
  assign q_zero   = (q_sum == '0);
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  // One restoring-division step per lane, and the saturated signed result.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mom_abs[i]  = q_mom[i][MOM_W-1] ? MOM_W'(-q_mom[i]) : q_mom[i];
      trial[i]    = {rem[i], dvd[i][NB-1]};
      fits[i]     = (trial[i] >= {1'b0, den});
      rem_next[i] = fits[i] ? SUM_W'(trial[i] - {1'b0, den}) : SUM_W'(trial[i]);
      if (sat[i] || quo[i][CW-1]) begin
        cent[i] = neg[i] ? icc_pkg::CENT_NEG_SAT : icc_pkg::CENT_POS_SAT;
      end else begin
        cent[i] = neg[i] ? CW'(-quo[i]) : quo[i];
      end
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            step  <= '0;
            state <= q_zero ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == SCW'(NB - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Divider datapath and result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_reg  <= q_sum;
      zero_reg <= q_zero;
      den      <= q_den;
    end
    for (int i = 0; i < 2; i++) begin
      if (q_pop) begin
        dvd[i] <= NB'(mom_abs[i]) << FRAC_BITS;
        rem[i] <= '0;
        quo[i] <= '0;
        sat[i] <= 1'b0;
        neg[i] <= !q_zero && (q_mom[i][MOM_W-1] != q_sum[SUM_W-1]);
      end else if (state == ST_DIV) begin
        dvd[i] <= dvd[i] << 1;
        rem[i] <= rem_next[i];
        quo[i] <= {quo[i][CW-2:0], fits[i]};
        sat[i] <= sat[i] || quo[i][CW-1];
      end
    end
    if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
      pixel_sum  <= icc_pkg::SUM_OUT_W'(sum_reg);
      centroid_x <= zero_reg ? '0 : cent[0];
      centroid_y <= zero_reg ? '0 : cent[1];
      zero_sum   <= zero_reg;
    end
  end

`include "image_intensity_centroid_assert.svh"

  `ICC_ASSERT_IMP(a_step_in_range, state == ST_DIV, step < SCW'(NB), "division step past the last bit")
  `ICC_ASSERT_IMP(a_zero_gives_zero, out_valid && zero_sum, centroid_x == '0 && centroid_y == '0, "zero sum with nonzero centroid")
  `ICC_ASSERT_NXT(a_done_delivers, state == ST_DONE && !(out_valid && out_stall), out_valid && state == ST_IDLE, "finished result not registered")

endmodule

// File: rtl/core/image_intensity_centroid.sv
// Channel   Direction  Handshake                Payload
// pixel     in         in_valid / in_stall      pixel
// result    out        out_valid / out_stall    pixel_sum, centroid_x, centroid_y, zero_sum
// config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Pixels are taken one per cycle; only a frame's last pixel can stall, when the
// two-entry frame queue has no free slot for its totals.
// Each frame result comes from the shared-denominator bit-serial divider, which works
// on a queued frame's totals while the front takes the next frame's pixels.
// The result register frees the divider, so out_stall holds only a finished result.
// Synchronous reset clears counters, sums, queue and handshakes, and loads the
// register defaults (640 by 480, pedestal 32); there is no clearing pass.
module image_intensity_centroid #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [icc_pkg::PIXEL_W-1:0]    pixel,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic [icc_pkg::SUM_OUT_W-1:0]  pixel_sum,
  output logic [icc_pkg::CENT_W-1:0]     centroid_x,
  output logic [icc_pkg::CENT_W-1:0]     centroid_y,
  output logic                           zero_sum,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [icc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int SUM_W   = icc_pkg::PIXEL_W + 1 + CW + RW;
  localparam int MOM_W   = SUM_W + ((CW > RW) ? CW : RW);
  localparam int Q_DEPTH = 2;
  localparam int QCW     = $clog2(Q_DEPTH + 1);
  localparam int QW      = SUM_W + 2 * MOM_W;

  icc_pkg::cfg_regs_t cfg;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic [QCW-1:0]     q_count;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= icc_pkg::WIDTH_RST;
      cfg.image_height <= icc_pkg::HEIGHT_RST;
      cfg.pedestal     <= icc_pkg::PED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        icc_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[icc_pkg::SIZE_W-1:0];
        icc_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[icc_pkg::SIZE_W-1:0];
        icc_pkg::REG_PEDESTAL:     cfg.pedestal     <= cfg_data[icc_pkg::PED_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: raster tracking and accumulation.
  icc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SUM_W      (SUM_W),
    .MOM_W      (MOM_W),
    .Q_DEPTH    (Q_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pixel    (pixel),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Frame totals queue between the two halves.
  icc_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  // Back: centroid division and result register.
  icc_back #(
    .SUM_W     (SUM_W),
    .MOM_W     (MOM_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .pixel_sum  (pixel_sum),
    .centroid_x (centroid_x),
    .centroid_y (centroid_y),
    .zero_sum   (zero_sum),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

// File: test/tb.sv
module tb;
  import icc_pkg::*;

  localparam int MAX_SIDE = 1024;
  localparam int FRAC_BITS = 8;
  localparam int RANDOM_ITEMS = 650;
  // Two queued frames through the divider plus a stalled result.
  localparam int DRAIN_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [PED_W-1:0] PED_MID = 16'h8000;

  // Pixel content styles for a generated frame.
  typedef enum int {
    PIX_RANDOM,
    PIX_NEAR_PED,
    PIX_AT_PED,
    PIX_SPIKES
  } pixel_style_t;

  typedef struct packed {
    logic [SUM_OUT_W-1:0] pixel_sum;
    logic [CENT_W-1:0]    centroid_x;
    logic [CENT_W-1:0]    centroid_y;
    logic                 zero_sum;
  } frame_result_t;

  // Tracks the frame accumulators and holds the frame results still due.
  class centroid_tracker;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [PED_W-1:0]  ped_reg;
    int unsigned col;
    int unsigned row;
    longint sum_acc;
    longint x_mom;
    longint y_mom;
    frame_result_t results_due[$];
    int errors;

    function new();
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      ped_reg = PED_RST;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col = 0;
      row = 0;
      sum_acc = 0;
      x_mom = 0;
      y_mom = 0;
    endfunction

    // A size of zero counts as one; anything past the maximum is clipped.
    function int unsigned frame_side(logic [SIZE_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_SIDE) return MAX_SIDE;
      return raw;
    endfunction

    // Moment over sum in fixed point, truncated toward zero, saturated.
    function logic [CENT_W-1:0] scaled_ratio(longint moment, longint total);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] mag;
      logic [63:0] neg_mag;
      bit neg;
      num = (moment < 0) ? -moment : moment;
      den = (total < 0) ? -total : total;
      neg = (moment < 0) != (total < 0);
      quo = num / den;
      rem = num % den;
      if (quo >= 64'h1_0000_0000) begin
        mag = 64'h1_0000_0000;
      end else begin
        mag = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / den);
      end
      if (neg) begin
        if (mag >= 64'h8000_0000) return CENT_NEG_SAT;
        neg_mag = 64'd0 - mag;
        return neg_mag[CENT_W-1:0];
      end
      if (mag > 64'h7FFF_FFFF) return CENT_POS_SAT;
      return mag[CENT_W-1:0];
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: width_reg = data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[SIZE_W-1:0];
        REG_PEDESTAL: ped_reg = data[PED_W-1:0];
        default: ;
      endcase
    endfunction

    // Accumulates one accepted pixel; a frame's last pixel queues its result.
    function void take_pixel(logic [PIXEL_W-1:0] value);
      int unsigned w;
      int unsigned h;
      longint v;
      logic [63:0] total_bits;
      frame_result_t res;
      w = frame_side(width_reg);
      h = frame_side(height_reg);
      v = longint'(value) - longint'(ped_reg);
      sum_acc += v;
      x_mom += longint'(col) * v;
      y_mom += longint'(row) * v;
      if (col + 1 < w) begin
        col++;
        return;
      end
      col = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      total_bits = sum_acc;
      res.pixel_sum = total_bits[SUM_OUT_W-1:0];
      if (sum_acc == 0) begin
        res.centroid_x = '0;
        res.centroid_y = '0;
        res.zero_sum = 1'b1;
      end else begin
        res.centroid_x = scaled_ratio(x_mom, sum_acc);
        res.centroid_y = scaled_ratio(y_mom, sum_acc);
        res.zero_sum = 1'b0;
      end
      results_due.push_back(res);
      clear_frame();
    endfunction

    function bit field_ok(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        return 0;
      end
      return 1;
    endfunction

    // Compares one accepted result with the oldest frame result due.
    function void check_result(logic [SUM_OUT_W-1:0] s, logic [CENT_W-1:0] cx,
                               logic [CENT_W-1:0] cy, logic zs);
      frame_result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, sum %h x %h y %h zero %b", $time, s, cx, cy, zs);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (!field_ok("pixel_sum", want.pixel_sum, s)) errors++;
      if (!field_ok("centroid_x", want.centroid_x, cx)) errors++;
      if (!field_ok("centroid_y", want.centroid_y, cy)) errors++;
      if (!field_ok("zero_sum", want.zero_sum, zs)) errors++;
    endfunction

    function int frames_pending();
      return results_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [PIXEL_W-1:0] pixel = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SUM_OUT_W-1:0] pixel_sum;
  logic [CENT_W-1:0] centroid_x;
  logic [CENT_W-1:0] centroid_y;
  logic zero_sum;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  centroid_tracker sb = new();
  bit in_gaps = 1'b0;
  bit calm = 1'b0;
  bit stall_on = 1'b1;
  int stall_left = 0;
  int random_items = 0;

  image_intensity_centroid i_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_sum (pixel_sum),
    .centroid_x(centroid_x),
    .centroid_y(centroid_y),
    .zero_sum  (zero_sum),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Result stalls come in bursts, with quiet stretches in between.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && stall_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result transaction is checked at the clock edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(pixel_sum, centroid_x, centroid_y, zero_sum);
    end
  end

  // Sends one pixel transaction, sometimes after an idle burst.
  task automatic put_pixel(input logic [PIXEL_W-1:0] value);
    int gap;
    gap = (in_gaps && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_pixel(value);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops the pixel stream and lets every frame result drain out.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.frames_pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIXEL_W-1:0] pick_pixel(pixel_style_t style);
    int p;
    case (style)
      PIX_NEAR_PED: begin
        p = int'(sb.ped_reg) + int'($urandom_range(0, 6)) - 3;
        if (p < 0) p = 0;
        if (p > 65535) p = 65535;
        return p[PIXEL_W-1:0];
      end
      PIX_AT_PED: return sb.ped_reg;
      PIX_SPIKES: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : sb.ped_reg;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // A wide frame with opposite extremes at its two ends, pedestal between.
  task automatic send_end_pair(input logic [PIXEL_W-1:0] first,
                               input logic [PIXEL_W-1:0] last);
    for (int i = 0; i < MAX_SIDE; i++) begin
      put_pixel(i == 0 ? first : (i == MAX_SIDE - 1 ? last : PED_MID));
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_side(int unsigned top);
    logic [CFG_DATA_W-1:0] data;
    int r;
    r = $urandom_range(0, 19);
    data = $urandom_range(0, 65535);
    if (r < 2) data[SIZE_W-1:0] = 0;
    else if (r < 16) data[SIZE_W-1:0] = $urandom_range(1, top);
    else data[SIZE_W-1:0] = $urandom_range(top + 1, 4 * top);
    return data;
  endfunction

  // Picks a new frame shape and pedestal; some registers keep their value.
  task automatic reconfigure();
    int r;
    logic [CFG_DATA_W-1:0] ped;
    if ($urandom_range(0, 2) != 0) write_register(REG_IMAGE_WIDTH, random_side(8));
    if ($urandom_range(0, 2) != 0) write_register(REG_IMAGE_HEIGHT, random_side(6));
    if ($urandom_range(0, 2) != 0) begin
      r = $urandom_range(0, 3);
      case (r)
        0: ped = 16'h0000;
        1: ped = 16'hFFFF;
        2: ped = $urandom_range(0, 64);
        default: ped = $urandom_range(0, 65535);
      endcase
      write_register(REG_PEDESTAL, ped);
    end
  endtask

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    pixel_style_t style;
    int frames;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Start a frame at the reset shape, then shrink it to one pixel.
    in_gaps = 1'b1;
    put_pixel(16'h0000);
    put_pixel(16'hFFFF);
    put_pixel(16'h0020);
    wait_idle();
    write_register(REG_IMAGE_WIDTH, 16'hF801);
    write_register(REG_IMAGE_HEIGHT, 16'h0000);
    put_pixel(16'h1234);
    put_pixel(16'h0000);
    put_pixel(16'hFFFF);

    // One-pixel frames at both pedestal extremes, including zero sums.
    wait_idle();
    write_register(REG_PEDESTAL, 16'h0000);
    put_pixel(16'h0000);
    put_pixel(16'hFFFF);
    wait_idle();
    write_register(REG_PEDESTAL, 16'hFFFF);
    put_pixel(16'hFFFF);
    put_pixel(16'h0000);
    put_pixel($urandom_range(0, 65535));

    // The unused register index must change nothing.
    wait_idle();
    write_register(REG_SPARE, $urandom_range(0, 65535));
    put_pixel(16'h5A5A);

    // Shrink the frame while it is half received.
    wait_idle();
    write_register(REG_PEDESTAL, PED_MID);
    write_register(REG_IMAGE_WIDTH, 16'd4);
    write_register(REG_IMAGE_HEIGHT, 16'd3);
    repeat (6) put_pixel(pick_pixel(PIX_RANDOM));
    wait_idle();
    write_register(REG_IMAGE_WIDTH, 16'd2);
    write_register(REG_IMAGE_HEIGHT, 16'd2);
    put_pixel(16'hC000);

    // Widest row: both saturation signs, then a sum that cancels to zero.
    wait_idle();
    write_register(REG_IMAGE_WIDTH, 16'hFFFF);
    write_register(REG_IMAGE_HEIGHT, 16'd1);
    send_end_pair(16'h0000, 16'hFFFF);
    send_end_pair(16'hFFFF, 16'h0000);
    send_end_pair(16'h0001, 16'hFFFF);

    // Tallest column, with an oversized height register.
    wait_idle();
    write_register(REG_IMAGE_WIDTH, 16'd1);
    write_register(REG_IMAGE_HEIGHT, 16'hFFFF);
    write_register(REG_PEDESTAL, $urandom_range(0, 65535));
    repeat (MAX_SIDE) put_pixel(pick_pixel(PIX_NEAR_PED));

    // Random frame shapes and contents; the tail runs without input gaps or result stalls.
    while (random_items < RANDOM_ITEMS) begin
      if (random_items > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
      in_gaps = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 3) != 0) begin
        wait_idle();
        reconfigure();
      end
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        style = pixel_style_t'($urandom_range(0, 3));
        do begin
          put_pixel(pick_pixel(style));
          random_items++;
        end while (sb.col != 0 || sb.row != 0);
      end
      // Leave a frame unfinished now and then, so the next shape lands mid-frame.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          put_pixel(pick_pixel(PIX_RANDOM));
          random_items++;
        end
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
